// ----- hdl/mcce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mcce_pkg;

    localparam int CORNER_W = 14;
    localparam int VERT_W   = 12;
    localparam int COORD_W  = 32;
    localparam int LABEL_W  = 14;
    localparam int COUNT_W  = 13;

    localparam int MAX_TRIANGLES_DEF = 4096;
    localparam int MAX_VERTICES_DEF  = 4096;
    localparam int STACK_DEPTH_DEF   = 1024;

    // Division by three as a multiply by a rounded-up reciprocal.
    localparam int DIV_K     = CORNER_W + 2;
    localparam int DIV_RECIP = (2 ** DIV_K + 2) / 3;

    typedef enum logic [1:0] {
        CMD_LOAD_CORNER = 2'd0,
        CMD_LOAD_VERTEX = 2'd1,
        CMD_START       = 2'd2,
        CMD_STEP        = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_VERTEX = 2'd1,
        REC_SYMBOL = 2'd2,
        REC_HANDLE = 2'd3
    } rec_kind_t;

    typedef enum logic [2:0] {
        SYM_C = 3'd0,
        SYM_L = 3'd1,
        SYM_E = 3'd2,
        SYM_R = 3'd3,
        SYM_S = 3'd4
    } symbol_t;

    typedef enum logic [2:0] {
        RS_HEADER,
        RS_VERTEX,
        RS_SYMBOL,
        RS_HANDLE_R,
        RS_HANDLE_L
    } rec_sel_t;

    typedef enum logic [2:0] {
        DQ_HOLD,
        DQ_CC,
        DQ_PREV,
        DQ_OPP,
        DQ_RC,
        DQ_STACK
    } dq_sel_t;

    typedef enum logic [1:0] {
        OR_NONE,
        OR_NEXT,
        OR_PREV,
        OR_DQ
    } opp_rd_t;

    typedef enum logic [1:0] {
        VR_NONE,
        VR_DQ,
        VR_PREV
    } vtx_rd_t;

    typedef enum logic [1:0] {
        VS_NONE,
        VS_A,
        VS_B,
        VS_V
    } vsel_t;

    typedef enum logic [1:0] {
        LW_NONE,
        LW_ONE,
        LW_SPLIT
    } lab_wr_t;

    typedef enum logic [2:0] {
        CC_HOLD,
        CC_OPP,
        CC_RC,
        CC_LC,
        CC_DQ
    } cc_ld_t;

    typedef struct packed {
        logic     take;
        logic     clr;
        dq_sel_t  dq_sel;
        opp_rd_t  opp_rd;
        vtx_rd_t  vtx_rd;
        vsel_t    coord_rd;
        vsel_t    mark_wr;
        logic     mark_rd;
        lab_wr_t  lab_wr;
        logic     lab_rd;
        logic     tri_c_ld;
        logic     t_inc;
        logic     fan_inc;
        logic     fan_one;
        logic     cap_va;
        logic     cap_vb;
        logic     cap_v;
        logic     cap_rc;
        logic     cap_lc;
        logic     cap_hr;
        logic     cap_hl;
        logic     fs_ld;
        cc_ld_t   cc_ld;
        logic     push;
        logic     pop;
        logic     emit;
        rec_sel_t rec_sel;
        symbol_t  sym;
        logic     last;
        logic     done;
        logic     err;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic clr_last;
        logic at_stop;
        logic marked;
        logic hr_gt1;
        logic hl_gt1;
        logic hr_nz;
        logic hl_nz;
        logic sp_zero;
        logic sp_full;
        logic lab_zero;
        logic mesh_kind;
        logic emit_header;
    } dp_status_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [CORNER_W-1:0] index;
        logic [VERT_W-1:0]   corner_vertex;
        logic [CORNER_W-1:0] corner_opposite;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic [COORD_W-1:0]  coord_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic [2:0]         symbol;
        logic               header_mesh_kind;
        logic [COUNT_W-1:0] fan_count;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_z;
        logic [LABEL_W-1:0] handle_from;
        logic [LABEL_W-1:0] handle_to;
        logic               last;
        logic               done_res;
        logic               error;
    } out_item_t;

endpackage
`default_nettype wire

// ----- hdl/mcce_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mcce_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [mcce_pkg::CORNER_W-1:0] index;
    logic [mcce_pkg::VERT_W-1:0]   corner_vertex;
    logic [mcce_pkg::CORNER_W-1:0] corner_opposite;
    logic [mcce_pkg::COORD_W-1:0]  coord_x;
    logic [mcce_pkg::COORD_W-1:0]  coord_y;
    logic [mcce_pkg::COORD_W-1:0]  coord_z;

    modport source (output valid, command, index, corner_vertex, corner_opposite,
                    coord_x, coord_y, coord_z, input ready);
    modport sink (input valid, command, index, corner_vertex, corner_opposite,
                  coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

// ----- hdl/mcce_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mcce_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   record_kind;
    logic [2:0]                   symbol;
    logic                         header_mesh_kind;
    logic [mcce_pkg::COUNT_W-1:0] fan_count;
    logic [mcce_pkg::COORD_W-1:0] out_x;
    logic [mcce_pkg::COORD_W-1:0] out_y;
    logic [mcce_pkg::COORD_W-1:0] out_z;
    logic [mcce_pkg::LABEL_W-1:0] handle_from;
    logic [mcce_pkg::LABEL_W-1:0] handle_to;
    logic                         last;
    logic                         done_res;
    logic                         error;

    modport source (output valid, record_kind, symbol, header_mesh_kind, fan_count,
                    out_x, out_y, out_z, handle_from, handle_to, last, done_res, error,
                    input ready);
    modport sink (input valid, record_kind, symbol, header_mesh_kind, fan_count,
                  out_x, out_y, out_z, handle_from, handle_to, last, done_res, error,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/mesh_connectivity_clers_encoder_core.sv -----
// Edgebreaker CLERS connectivity encoder over a corner table.
// Input channel in_ch: one transaction per command. Load corner and load
// vertex write the corner table and coordinate store and leave the block
// idle. Start clears vertex marks and triangle labels in a pass over all
// their entries before the next transaction is taken. Each step transaction
// advances the traversal and puts zero to four records on out_ch, the last
// one flagged by last. After a step is taken the block is busy before it
// takes the next transaction, and longer while a record waits on a stalled
// receiver. The cost is set by the chain of dependent reads of the corner,
// mark and label memories, each with one read port, and the divide-by-three
// unit. An E step that pops the split stack also reads the triangle label
// of each popped corner before the next transaction is taken.
// out_ch is fed from one output register; the controller stalls while a
// record is still waiting, so nothing is lost when the receiver stalls.
// Configuration (cfg_we, cfg_index, cfg_data) writes mesh_kind (index 0)
// and emit_header (index 1) and must only be used while the block is idle.
// After reset the traversal is idle, mesh_kind is 0 and emit_header is 1;
// the corner table and coordinates are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module mesh_connectivity_clers_encoder_core #(
    parameter int MAX_TRIANGLES = mcce_pkg::MAX_TRIANGLES_DEF,
    parameter int MAX_VERTICES  = mcce_pkg::MAX_VERTICES_DEF,
    parameter int STACK_DEPTH   = mcce_pkg::STACK_DEPTH_DEF
) (
    input wire         clk,
    input wire         rst_n,
    mcce_in_if.sink    in_ch,
    mcce_out_if.source out_ch,
    input wire         cfg_we,
    input wire         cfg_index,
    input wire         cfg_data
);
    mcce_pkg::dp_cmd_t    cmd;
    mcce_pkg::dp_status_t status;
    mcce_pkg::in_item_t   item;
    mcce_pkg::out_item_t  out_item;
    logic                 out_valid;
    logic                 ready;

    assign item.command         = in_ch.command;
    assign item.index           = in_ch.index;
    assign item.corner_vertex   = in_ch.corner_vertex;
    assign item.corner_opposite = in_ch.corner_opposite;
    assign item.coord_x         = in_ch.coord_x;
    assign item.coord_y         = in_ch.coord_y;
    assign item.coord_z         = in_ch.coord_z;
    assign in_ch.ready          = ready;

    mcce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (ready),
        .status     (status),
        .cmd        (cmd)
    );

    mcce_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .MAX_VERTICES  (MAX_VERTICES),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );

    assign out_ch.valid            = out_valid;
    assign out_ch.record_kind      = out_item.record_kind;
    assign out_ch.symbol           = out_item.symbol;
    assign out_ch.header_mesh_kind = out_item.header_mesh_kind;
    assign out_ch.fan_count        = out_item.fan_count;
    assign out_ch.out_x            = out_item.out_x;
    assign out_ch.out_y            = out_item.out_y;
    assign out_ch.out_z            = out_item.out_z;
    assign out_ch.handle_from      = out_item.handle_from;
    assign out_ch.handle_to        = out_item.handle_to;
    assign out_ch.last             = out_item.last;
    assign out_ch.done_res         = out_item.done_res;
    assign out_ch.error            = out_item.error;
endmodule
`default_nettype wire

// ----- hdl/mcce_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mcce_dp #(
    parameter int MAX_TRIANGLES = mcce_pkg::MAX_TRIANGLES_DEF,
    parameter int MAX_VERTICES  = mcce_pkg::MAX_VERTICES_DEF,
    parameter int STACK_DEPTH   = mcce_pkg::STACK_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mcce_pkg::dp_cmd_t    cmd,
    output mcce_pkg::dp_status_t status,
    input  mcce_pkg::in_item_t   item,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire                  cfg_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output mcce_pkg::out_item_t  out_item
);
    localparam int NC    = 3 * MAX_TRIANGLES;
    localparam int CAW   = $clog2(NC);
    localparam int VAW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TAW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int SAW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int CLR_N = (MAX_VERTICES > MAX_TRIANGLES) ? MAX_VERTICES : MAX_TRIANGLES;
    localparam int CLW   = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int CW    = mcce_pkg::CORNER_W;
    localparam int LW    = mcce_pkg::LABEL_W;
    localparam int PW    = CW + mcce_pkg::DIV_K;
    localparam int XW    = 3 * mcce_pkg::COORD_W;

    // Corner table and vertex store.
    logic [VAW-1:0] vtx_mem [NC];
    logic [CW-1:0]  opp_mem [NC];
    logic [XW-1:0]  coord_mem [MAX_VERTICES];
    logic           mark_mem [MAX_VERTICES];
    logic [LW-1:0]  lab_mem [MAX_TRIANGLES];
    logic [CW-1:0]  stk_mem [STACK_DEPTH];

    logic [VAW-1:0] vtx_q;
    logic [CW-1:0]  opp_q;
    logic [XW-1:0]  coord_q;
    logic           mark_q;
    logic [LW-1:0]  lab_q;
    logic [CW-1:0]  stk_q;

    logic                           mesh_kind_reg;
    logic                           emit_header_reg;
    logic [CW-1:0]                  cc_reg;
    logic [CW-1:0]                  fs_reg;
    logic [mcce_pkg::COUNT_W-1:0]   t_reg;
    logic [mcce_pkg::COUNT_W-1:0]   fan_reg;
    logic [SPW-1:0]                 sp_reg;
    logic [CLW-1:0]                 clr_reg;
    logic                           out_valid_reg;

    logic [CW-1:0]  dq_reg;
    logic [CW-1:0]  dt_reg;
    logic [1:0]     dr_reg;
    logic [TAW-1:0] tri_c_reg;
    logic [VAW-1:0] va_reg;
    logic [VAW-1:0] vb_reg;
    logic [VAW-1:0] v_reg;
    logic [CW-1:0]  rc_reg;
    logic [CW-1:0]  lc_reg;
    logic [LW-1:0]  hr_reg;
    logic [LW-1:0]  hl_reg;
    mcce_pkg::out_item_t out_reg;

    logic [PW-1:0]  prod;
    logic [CW-1:0]  quo;
    logic [CW-1:0]  rem;
    logic [CW-1:0]  nx;
    logic [CW-1:0]  pv;
    logic [LW-1:0]  t3;
    logic           take_corner;
    logic           take_vertex;
    logic           take_start;
    logic           mark_we;
    logic [VAW-1:0] mark_wa;
    logic           mark_wd;
    logic           lab_we;
    logic [TAW-1:0] lab_wa;
    logic [LW-1:0]  lab_wd;
    logic [VAW-1:0] coord_ra;
    logic [CW-1:0]  opp_ra;
    logic [CW-1:0]  vtx_ra;
    logic [CW-1:0]  dq_next;
    logic [CW-1:0]  cc_next;
    mcce_pkg::out_item_t rec;

    // Triangle and position within it of the corner held in dq_reg.
    assign prod = PW'(dq_reg) * PW'(mcce_pkg::DIV_RECIP);
    assign quo  = prod[PW-1:mcce_pkg::DIV_K];
    assign rem  = dq_reg - ((quo << 1) + quo);
    assign nx   = (dr_reg == 2'd2) ? dq_reg - CW'(2) : dq_reg + CW'(1);
    assign pv   = (dr_reg == 2'd0) ? dq_reg + CW'(2) : dq_reg - CW'(1);
    assign t3   = LW'({t_reg, 1'b0}) + LW'(t_reg);

    assign take_corner = cmd.take && (item.command == mcce_pkg::CMD_LOAD_CORNER)
                         && (32'(item.index) < 32'(NC));
    assign take_vertex = cmd.take && (item.command == mcce_pkg::CMD_LOAD_VERTEX)
                         && (32'(item.index) < 32'(MAX_VERTICES));
    assign take_start  = cmd.take && (item.command == mcce_pkg::CMD_START);

    always_comb
    begin
        opp_ra = dq_reg;
        case (cmd.opp_rd)
            mcce_pkg::OR_NEXT: opp_ra = nx;
            mcce_pkg::OR_PREV: opp_ra = pv;
            default:           opp_ra = dq_reg;
        endcase
        vtx_ra = (cmd.vtx_rd == mcce_pkg::VR_PREV) ? pv : dq_reg;
        case (cmd.coord_rd)
            mcce_pkg::VS_A: coord_ra = va_reg;
            mcce_pkg::VS_B: coord_ra = vb_reg;
            default:        coord_ra = v_reg;
        endcase
        mark_we = 1'b1;
        mark_wd = 1'b1;
        case (cmd.mark_wr)
            mcce_pkg::VS_A: mark_wa = va_reg;
            mcce_pkg::VS_B: mark_wa = vb_reg;
            mcce_pkg::VS_V: mark_wa = v_reg;
            default:
            begin
                mark_wa = VAW'(clr_reg);
                mark_wd = 1'b0;
                mark_we = cmd.clr && (32'(clr_reg) < 32'(MAX_VERTICES));
            end
        endcase
        case (cmd.lab_wr)
            mcce_pkg::LW_ONE:
            begin
                lab_we = 1'b1;
                lab_wa = TAW'(dt_reg);
                lab_wd = LW'(1);
            end
            mcce_pkg::LW_SPLIT:
            begin
                lab_we = 1'b1;
                lab_wa = tri_c_reg;
                lab_wd = t3 + LW'(2);
            end
            default:
            begin
                lab_we = cmd.clr && (32'(clr_reg) < 32'(MAX_TRIANGLES));
                lab_wa = TAW'(clr_reg);
                lab_wd = '0;
            end
        endcase
        case (cmd.dq_sel)
            mcce_pkg::DQ_CC:    dq_next = cc_reg;
            mcce_pkg::DQ_PREV:  dq_next = pv;
            mcce_pkg::DQ_OPP:   dq_next = opp_q;
            mcce_pkg::DQ_RC:    dq_next = rc_reg;
            mcce_pkg::DQ_STACK: dq_next = stk_q;
            default:            dq_next = dq_reg;
        endcase
        case (cmd.cc_ld)
            mcce_pkg::CC_OPP: cc_next = opp_q;
            mcce_pkg::CC_RC:  cc_next = rc_reg;
            mcce_pkg::CC_LC:  cc_next = lc_reg;
            mcce_pkg::CC_DQ:  cc_next = dq_reg;
            default:          cc_next = cc_reg;
        endcase
    end

    always_comb
    begin
        rec = '0;
        rec.last = cmd.last;
        case (cmd.rec_sel)
            mcce_pkg::RS_HEADER:
            begin
                rec.record_kind      = mcce_pkg::REC_HEADER;
                rec.header_mesh_kind = mesh_kind_reg;
                rec.fan_count        = fan_reg;
            end
            mcce_pkg::RS_VERTEX:
            begin
                rec.record_kind = mcce_pkg::REC_VERTEX;
                rec.out_x = coord_q[XW-1 -: mcce_pkg::COORD_W];
                rec.out_y = coord_q[2*mcce_pkg::COORD_W-1 -: mcce_pkg::COORD_W];
                rec.out_z = coord_q[mcce_pkg::COORD_W-1:0];
            end
            mcce_pkg::RS_HANDLE_R:
            begin
                rec.record_kind = mcce_pkg::REC_HANDLE;
                rec.handle_from = hr_reg;
                rec.handle_to   = t3 + LW'(1);
            end
            mcce_pkg::RS_HANDLE_L:
            begin
                rec.record_kind = mcce_pkg::REC_HANDLE;
                rec.handle_from = hl_reg;
                rec.handle_to   = t3 + LW'(2);
            end
            default:
            begin
                rec.record_kind = mcce_pkg::REC_SYMBOL;
                rec.symbol      = cmd.sym;
                rec.done_res    = cmd.done;
                rec.error       = cmd.err;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_corner)
        begin
            vtx_mem[CAW'(item.index)] <= (32'(item.corner_vertex) < 32'(MAX_VERTICES))
                                         ? VAW'(item.corner_vertex) : '0;
        end
        if (cmd.vtx_rd != mcce_pkg::VR_NONE)
        begin
            vtx_q <= vtx_mem[CAW'(vtx_ra)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_corner)
        begin
            opp_mem[CAW'(item.index)] <= (32'(item.corner_opposite) < 32'(NC))
                                         ? item.corner_opposite : '0;
        end
        if (cmd.opp_rd != mcce_pkg::OR_NONE)
        begin
            opp_q <= opp_mem[CAW'(opp_ra)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_vertex)
        begin
            coord_mem[VAW'(item.index)] <= {item.coord_x, item.coord_y, item.coord_z};
        end
        if (cmd.coord_rd != mcce_pkg::VS_NONE)
        begin
            coord_q <= coord_mem[coord_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        if (cmd.mark_rd)
        begin
            mark_q <= mark_mem[v_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_wa] <= lab_wd;
        end
        if (cmd.lab_rd)
        begin
            lab_q <= lab_mem[TAW'(dt_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_mem[SAW'(sp_reg)] <= lc_reg;
        end
        if (cmd.pop)
        begin
            stk_q <= stk_mem[SAW'(sp_reg - SPW'(1))];
        end
    end

    // Working registers of the traversal.
    always_ff @(posedge clk)
    begin
        dq_reg <= dq_next;
        dt_reg <= quo;
        dr_reg <= rem[1:0];
        if (cmd.tri_c_ld) tri_c_reg <= TAW'(dt_reg);
        if (cmd.cap_va)   va_reg <= vtx_q;
        if (cmd.cap_vb)   vb_reg <= vtx_q;
        if (cmd.cap_v)    v_reg <= vtx_q;
        if (cmd.cap_rc)   rc_reg <= opp_q;
        if (cmd.cap_lc)   lc_reg <= opp_q;
        if (cmd.cap_hr)   hr_reg <= lab_q;
        if (cmd.cap_hl)   hl_reg <= lab_q;
        if (cmd.emit)     out_reg <= rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_kind_reg   <= 1'b0;
            emit_header_reg <= 1'b1;
            cc_reg          <= '0;
            fs_reg          <= '0;
            t_reg           <= '0;
            fan_reg         <= '0;
            sp_reg          <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index) emit_header_reg <= cfg_data;
                else           mesh_kind_reg <= cfg_data;
            end
            if (take_start)
            begin
                cc_reg  <= (32'(item.index) < 32'(NC)) ? item.index : '0;
                fs_reg  <= '0;
                t_reg   <= '0;
                fan_reg <= '0;
                sp_reg  <= '0;
                clr_reg <= '0;
            end
            else
            begin
                cc_reg <= cc_next;
                if (cmd.fs_ld)   fs_reg <= pv;
                if (cmd.t_inc)   t_reg <= t_reg + 1'b1;
                if (cmd.fan_one) fan_reg <= mcce_pkg::COUNT_W'(1);
                else if (cmd.fan_inc) fan_reg <= fan_reg + 1'b1;
                if (cmd.push)    sp_reg <= sp_reg + 1'b1;
                else if (cmd.pop) sp_reg <= sp_reg - 1'b1;
                if (cmd.clr)     clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.emit)           out_valid_reg <= 1'b1;
            else if (out_ready)     out_valid_reg <= 1'b0;
        end
    end

    assign status.slot_free   = !out_valid_reg || out_ready;
    assign status.clr_last    = (clr_reg == CLW'(CLR_N - 1));
    assign status.at_stop     = (cc_reg == fs_reg);
    assign status.marked      = mark_q;
    assign status.hr_gt1      = (hr_reg > LW'(1));
    assign status.hl_gt1      = (hl_reg > LW'(1));
    assign status.hr_nz       = (hr_reg != '0);
    assign status.hl_nz       = (hl_reg != '0);
    assign status.sp_zero     = (sp_reg == '0);
    assign status.sp_full     = (32'(sp_reg) >= 32'(STACK_DEPTH));
    assign status.lab_zero    = (lab_q == '0);
    assign status.mesh_kind   = mesh_kind_reg;
    assign status.emit_header = emit_header_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
endmodule
`default_nettype wire

// ----- hdl/mcce_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mcce_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire [1:0]            in_command,
    output logic                 in_ready,
    input  mcce_pkg::dp_status_t status,
    output mcce_pkg::dp_cmd_t    cmd
);
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INIT,
        PH_FAN,
        PH_WALK,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [5:0] {
        S_IDLE, S_CLR,
        S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8, S_I9, S_I10, S_I11,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_FH,
        S_W0, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_W7, S_W8, S_W9, S_W10,
        S_W11, S_W12,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                begin
                    case (in_command)
                        mcce_pkg::CMD_START: state_next = S_CLR;
                        mcce_pkg::CMD_STEP:
                        begin
                            case (phase_reg)
                                PH_INIT: state_next = S_I0;
                                PH_FAN:  state_next = S_F0;
                                PH_WALK: state_next = S_W0;
                                default: state_next = S_IDLE;
                            endcase
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                begin
                    phase_next = PH_INIT;
                    state_next = S_IDLE;
                end
            end
            // First step: the three vertices of the start triangle.
            S_I0: begin cmd.dq_sel = mcce_pkg::DQ_CC; state_next = S_I1; end
            S_I1: state_next = S_I2;
            S_I2:
            begin
                cmd.lab_wr = mcce_pkg::LW_ONE;
                cmd.opp_rd = mcce_pkg::OR_NEXT;
                cmd.vtx_rd = mcce_pkg::VR_DQ;
                cmd.dq_sel = mcce_pkg::DQ_PREV;
                state_next = S_I3;
            end
            S_I3:
            begin
                cmd.cap_va = 1'b1;
                cmd.cap_rc = 1'b1;
                cmd.opp_rd = mcce_pkg::OR_DQ;
                cmd.vtx_rd = mcce_pkg::VR_DQ;
                state_next = S_I4;
            end
            S_I4:
            begin
                cmd.cap_vb = 1'b1;
                cmd.cap_lc = 1'b1;
                cmd.vtx_rd = mcce_pkg::VR_PREV;
                cmd.dq_sel = mcce_pkg::DQ_RC;
                state_next = S_I5;
            end
            S_I5: begin cmd.cap_v = 1'b1; state_next = S_I6; end
            S_I6:
            begin
                cmd.fs_ld    = 1'b1;
                cmd.coord_rd = mcce_pkg::VS_A;
                if (!status.mesh_kind) cmd.mark_wr = mcce_pkg::VS_A;
                state_next = S_I7;
            end
            S_I7:
            begin
                cmd.rec_sel = mcce_pkg::RS_VERTEX;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_I8; end
            end
            S_I8:
            begin
                cmd.coord_rd = mcce_pkg::VS_B;
                cmd.mark_wr  = mcce_pkg::VS_B;
                state_next   = S_I9;
            end
            S_I9:
            begin
                cmd.rec_sel = mcce_pkg::RS_VERTEX;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_I10; end
            end
            S_I10:
            begin
                cmd.coord_rd = mcce_pkg::VS_V;
                cmd.mark_wr  = mcce_pkg::VS_V;
                state_next   = S_I11;
            end
            S_I11:
            begin
                cmd.rec_sel = mcce_pkg::RS_VERTEX;
                cmd.last    = 1'b1;
                if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.cc_ld   = mcce_pkg::CC_LC;
                    cmd.fan_one = 1'b1;
                    phase_next  = PH_FAN;
                    state_next  = S_IDLE;
                end
            end
            // Fan steps: one vertex each, then the header if emit_header is set.
            S_F0: begin cmd.dq_sel = mcce_pkg::DQ_CC; state_next = S_F1; end
            S_F1: state_next = S_F2;
            S_F2:
            begin
                cmd.lab_wr  = mcce_pkg::LW_ONE;
                cmd.t_inc   = 1'b1;
                cmd.fan_inc = 1'b1;
                if (status.at_stop)
                begin
                    cmd.opp_rd = mcce_pkg::OR_PREV;
                    state_next = S_FH;
                end
                else
                begin
                    cmd.vtx_rd = mcce_pkg::VR_DQ;
                    cmd.opp_rd = mcce_pkg::OR_NEXT;
                    state_next = S_F3;
                end
            end
            S_F3:
            begin
                cmd.cap_v  = 1'b1;
                cmd.cc_ld  = mcce_pkg::CC_OPP;
                state_next = S_F4;
            end
            S_F4:
            begin
                cmd.coord_rd = mcce_pkg::VS_V;
                cmd.mark_wr  = mcce_pkg::VS_V;
                state_next   = S_F5;
            end
            S_F5:
            begin
                cmd.rec_sel = mcce_pkg::RS_VERTEX;
                cmd.last    = 1'b1;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
            end
            S_FH:
            begin
                cmd.cc_ld   = mcce_pkg::CC_OPP;
                cmd.rec_sel = mcce_pkg::RS_HEADER;
                cmd.last    = 1'b1;
                phase_next  = PH_WALK;
                if (!status.emit_header)
                begin
                    state_next = S_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // Walk steps: one triangle each.
            S_W0: begin cmd.dq_sel = mcce_pkg::DQ_CC; state_next = S_W1; end
            S_W1: state_next = S_W2;
            S_W2:
            begin
                cmd.lab_wr   = mcce_pkg::LW_ONE;
                cmd.tri_c_ld = 1'b1;
                cmd.t_inc    = 1'b1;
                cmd.opp_rd   = mcce_pkg::OR_NEXT;
                cmd.vtx_rd   = mcce_pkg::VR_DQ;
                state_next   = S_W3;
            end
            S_W3:
            begin
                cmd.cap_rc = 1'b1;
                cmd.cap_v  = 1'b1;
                cmd.opp_rd = mcce_pkg::OR_PREV;
                cmd.dq_sel = mcce_pkg::DQ_OPP;
                state_next = S_W4;
            end
            S_W4:
            begin
                cmd.cap_lc  = 1'b1;
                cmd.dq_sel  = mcce_pkg::DQ_OPP;
                cmd.mark_rd = 1'b1;
                state_next  = S_W5;
            end
            S_W5:
            begin
                cmd.lab_rd   = 1'b1;
                cmd.coord_rd = mcce_pkg::VS_V;
                state_next   = S_W6;
            end
            S_W6:
            begin
                cmd.cap_hr = 1'b1;
                cmd.lab_rd = 1'b1;
                state_next = S_W7;
            end
            S_W7: begin cmd.cap_hl = 1'b1; state_next = S_W8; end
            S_W8:
            begin
                cmd.rec_sel = mcce_pkg::RS_HANDLE_R;
                if (!status.hr_gt1)
                begin
                    state_next = S_W9;
                end
                else if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_W9;
                end
            end
            S_W9:
            begin
                cmd.rec_sel = mcce_pkg::RS_HANDLE_L;
                if (!status.hl_gt1)
                begin
                    state_next = S_W10;
                end
                else if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_W10;
                end
            end
            S_W10:
            begin
                cmd.rec_sel = mcce_pkg::RS_SYMBOL;
                if (!status.marked)
                begin
                    cmd.sym = mcce_pkg::SYM_C;
                    if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_W11; end
                end
                else if (status.hr_nz && status.hl_nz)
                begin
                    state_next = S_E0;
                end
                else if (status.hr_nz)
                begin
                    cmd.sym   = mcce_pkg::SYM_R;
                    cmd.last  = 1'b1;
                    cmd.cc_ld = mcce_pkg::CC_LC;
                    if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
                end
                else if (status.hl_nz)
                begin
                    cmd.sym   = mcce_pkg::SYM_L;
                    cmd.last  = 1'b1;
                    cmd.cc_ld = mcce_pkg::CC_RC;
                    if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
                end
                else
                begin
                    cmd.sym    = mcce_pkg::SYM_S;
                    cmd.last   = 1'b1;
                    cmd.lab_wr = mcce_pkg::LW_SPLIT;
                    if (status.sp_full)
                    begin
                        // The traversal stops here until the next start.
                        cmd.err    = 1'b1;
                        phase_next = PH_ERROR;
                        if (status.slot_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        cmd.cc_ld  = mcce_pkg::CC_RC;
                        state_next = S_W12;
                    end
                end
            end
            S_W11:
            begin
                cmd.rec_sel = mcce_pkg::RS_VERTEX;
                cmd.last    = 1'b1;
                cmd.mark_wr = mcce_pkg::VS_V;
                cmd.cc_ld   = mcce_pkg::CC_RC;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
            end
            S_W12:
            begin
                cmd.rec_sel = mcce_pkg::RS_SYMBOL;
                cmd.sym     = mcce_pkg::SYM_S;
                cmd.last    = 1'b1;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
            end
            // On E, pop pending corners until one lies in an unvisited triangle or the stack is empty.
            S_E0:
            begin
                if (status.sp_zero)
                begin
                    phase_next = PH_DONE;
                    state_next = S_E5;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_E1;
                end
            end
            S_E1: begin cmd.dq_sel = mcce_pkg::DQ_STACK; state_next = S_E2; end
            S_E2: state_next = S_E3;
            S_E3: begin cmd.lab_rd = 1'b1; state_next = S_E4; end
            S_E4:
            begin
                if (status.lab_zero)
                begin
                    cmd.cc_ld  = mcce_pkg::CC_DQ;
                    state_next = S_E6;
                end
                else
                begin
                    state_next = S_E0;
                end
            end
            S_E5:
            begin
                cmd.rec_sel = mcce_pkg::RS_SYMBOL;
                cmd.sym     = mcce_pkg::SYM_E;
                cmd.done    = 1'b1;
                cmd.last    = 1'b1;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
            end
            S_E6:
            begin
                cmd.rec_sel = mcce_pkg::RS_SYMBOL;
                cmd.sym     = mcce_pkg::SYM_E;
                cmd.last    = 1'b1;
                if (status.slot_free) begin cmd.emit = 1'b1; state_next = S_IDLE; end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end
endmodule
`default_nettype wire

// ----- verif/mcce_tb_pkg.sv -----
`timescale 1ns / 1ps
package mcce_tb_pkg;

    // Configuration register indexes.
    localparam logic CFG_MESH_KIND   = 1'b0;
    localparam logic CFG_EMIT_HEADER = 1'b1;

    localparam int NUM_TRIS    = 4096;
    localparam int NUM_VERTS   = 4096;
    localparam int NUM_CORNERS = 3 * NUM_TRIS;
    localparam int SPLIT_DEPTH = 1024;

endpackage

// ----- verif/mcce_clers_checker.sv -----
`timescale 1ns / 1ps
module mcce_clers_checker
    import mcce_pkg::*;
    import mcce_tb_pkg::*;
(
    input  wire clk,
    input  wire rst_n,
    mcce_in_if  in_mon,
    mcce_out_if out_mon,
    input  wire cfg_we,
    input  wire cfg_index,
    input  wire cfg_data,
    output int  mismatches,
    output int  pending,
    output int  records_checked,
    output int  done_seen,
    output int  overflow_seen
);

    typedef enum logic [2:0] {
        TR_IDLE,
        TR_INIT,
        TR_FAN,
        TR_WALK,
        TR_DONE,
        TR_ABORT
    } trav_t;

    logic [VERT_W-1:0]   corner_vert [NUM_CORNERS];
    logic [CORNER_W-1:0] corner_opp  [NUM_CORNERS];
    logic [COORD_W-1:0]  pos_x [NUM_VERTS];
    logic [COORD_W-1:0]  pos_y [NUM_VERTS];
    logic [COORD_W-1:0]  pos_z [NUM_VERTS];
    bit                  marked [NUM_VERTS];
    logic [LABEL_W-1:0]  tri_label [NUM_TRIS];
    logic [CORNER_W-1:0] split_stack [SPLIT_DEPTH];
    int                  split_sp;
    logic [COUNT_W-1:0]  tri_count;
    logic [COUNT_W-1:0]  fan_count;
    logic [CORNER_W-1:0] cur_corner;
    logic [CORNER_W-1:0] fan_stop;
    trav_t               trav;
    logic                mesh_kind;
    logic                emit_header;
    int                  fails;
    int                  n_checked;
    int                  n_done;
    int                  n_overflow;

    out_item_t expected_records[$];
    out_item_t step_records[$];

    function automatic int unsigned nxt_c(int unsigned c);
        return c - c % 3 + (c % 3 + 1) % 3;
    endfunction

    function automatic int unsigned prv_c(int unsigned c);
        return nxt_c(nxt_c(c));
    endfunction

    function automatic int unsigned tri_of(int unsigned c);
        return (c % NUM_CORNERS) / 3;
    endfunction

    function automatic int unsigned opp_of(int unsigned c);
        return corner_opp[c % NUM_CORNERS];
    endfunction

    function automatic int unsigned vert_of(int unsigned c);
        return corner_vert[c % NUM_CORNERS];
    endfunction

    function automatic out_item_t make_rec(rec_kind_t kind);
        out_item_t r;
        r = '0;
        r.record_kind = kind;
        return r;
    endfunction

    task automatic add_vertex(int unsigned v);
        out_item_t r;
        r = make_rec(REC_VERTEX);
        r.out_x = pos_x[v];
        r.out_y = pos_y[v];
        r.out_z = pos_z[v];
        step_records.push_back(r);
    endtask

    task automatic add_handle(int unsigned from_lab, int unsigned to_lab);
        out_item_t r;
        r = make_rec(REC_HANDLE);
        r.handle_from = LABEL_W'(from_lab);
        r.handle_to   = LABEL_W'(to_lab);
        step_records.push_back(r);
    endtask

    task automatic init_step();
        int unsigned c;
        int unsigned v;
        c = prv_c(cur_corner);
        v = vert_of(nxt_c(c));
        add_vertex(v);
        if (mesh_kind == 1'b0)
            marked[v] = 1;
        v = vert_of(c);
        add_vertex(v);
        marked[v] = 1;
        v = vert_of(prv_c(c));
        add_vertex(v);
        marked[v] = 1;
        tri_label[tri_of(c)] = 1;
        cur_corner = opp_of(c);
        fan_count = 1;
        fan_stop = prv_c(opp_of(prv_c(c)));
        trav = TR_FAN;
    endtask

    task automatic fan_step();
        int unsigned a;
        int unsigned v;
        out_item_t   r;
        a = cur_corner;
        tri_label[tri_of(a)] = 1;
        tri_count = tri_count + 1'b1;
        fan_count = fan_count + 1'b1;
        if (a != fan_stop) begin
            v = vert_of(a);
            add_vertex(v);
            marked[v] = 1;
            cur_corner = opp_of(nxt_c(a));
        end
        else begin
            if (emit_header) begin
                r = make_rec(REC_HEADER);
                r.header_mesh_kind = mesh_kind;
                r.fan_count = fan_count;
                step_records.push_back(r);
            end
            cur_corner = opp_of(prv_c(a));
            trav = TR_WALK;
        end
    endtask

    task automatic walk_step();
        int unsigned c;
        int unsigned rc;
        int unsigned lc;
        int unsigned h;
        int unsigned v;
        int unsigned t3;
        out_item_t   srec;
        c = cur_corner;
        tri_label[tri_of(c)] = 1;
        tri_count = tri_count + 1'b1;
        t3 = int'(tri_count) * 3;
        rc = opp_of(nxt_c(c));
        lc = opp_of(prv_c(c));
        h = tri_label[tri_of(rc)];
        if (h > 1)
            add_handle(h, t3 + 1);
        h = tri_label[tri_of(lc)];
        if (h > 1)
            add_handle(h, t3 + 2);
        v = vert_of(c);
        srec = make_rec(REC_SYMBOL);
        if (!marked[v]) begin
            srec.symbol = SYM_C;
            step_records.push_back(srec);
            add_vertex(v);
            marked[v] = 1;
            cur_corner = rc;
        end
        else if (tri_label[tri_of(rc)] != 0 && tri_label[tri_of(lc)] != 0) begin
            srec.symbol = SYM_E;
            // Pop pending left branches until one lands in an unvisited triangle or the stack is empty.
            while (1) begin
                if (split_sp == 0) begin
                    trav = TR_DONE;
                    srec.done_res = 1'b1;
                    break;
                end
                split_sp--;
                c = split_stack[split_sp];
                if (tri_label[tri_of(c)] == 0) begin
                    cur_corner = c;
                    break;
                end
            end
            step_records.push_back(srec);
        end
        else if (tri_label[tri_of(rc)] != 0) begin
            srec.symbol = SYM_R;
            step_records.push_back(srec);
            cur_corner = lc;
        end
        else if (tri_label[tri_of(lc)] != 0) begin
            srec.symbol = SYM_L;
            step_records.push_back(srec);
            cur_corner = rc;
        end
        else begin
            srec.symbol = SYM_S;
            tri_label[tri_of(c)] = LABEL_W'(t3 + 2);
            if (split_sp >= SPLIT_DEPTH) begin
                srec.error = 1'b1;
                trav = TR_ABORT;
            end
            else begin
                split_stack[split_sp] = lc;
                split_sp++;
                cur_corner = rc;
            end
            step_records.push_back(srec);
        end
    endtask

    task automatic predict_records(in_item_t it);
        out_item_t r;
        step_records.delete();
        case (command_t'(it.command))
            CMD_LOAD_CORNER: begin
                if (it.index < NUM_CORNERS) begin
                    corner_vert[it.index] = (it.corner_vertex < NUM_VERTS) ? it.corner_vertex : '0;
                    corner_opp[it.index]  =
                        (it.corner_opposite < NUM_CORNERS) ? it.corner_opposite : '0;
                end
            end
            CMD_LOAD_VERTEX: begin
                if (it.index < NUM_VERTS) begin
                    pos_x[it.index] = it.coord_x;
                    pos_y[it.index] = it.coord_y;
                    pos_z[it.index] = it.coord_z;
                end
            end
            CMD_START: begin
                for (int i = 0; i < NUM_VERTS; i++)
                    marked[i] = 0;
                for (int i = 0; i < NUM_TRIS; i++)
                    tri_label[i] = '0;
                tri_count = '0;
                split_sp = 0;
                fan_count = '0;
                fan_stop = '0;
                cur_corner = (it.index < NUM_CORNERS) ? it.index : '0;
                trav = TR_INIT;
            end
            default: begin
                case (trav)
                    TR_INIT: init_step();
                    TR_FAN:  fan_step();
                    TR_WALK: walk_step();
                    default: ;
                endcase
            end
        endcase
        if (step_records.size() > 0) begin
            r = step_records.pop_back();
            r.last = 1'b1;
            step_records.push_back(r);
        end
        foreach (step_records[i])
            expected_records.push_back(step_records[i]);
    endtask

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        fails++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic compare_record();
        out_item_t want;
        if (expected_records.size() == 0) begin
            report($sformatf("record kind %0d arrived with nothing expected",
                             out_mon.record_kind));
            return;
        end
        want = expected_records.pop_front();
        n_checked++;
        if (want.done_res)
            n_done++;
        if (want.error)
            n_overflow++;
        check_field("record_kind", out_mon.record_kind, want.record_kind);
        check_field("symbol", out_mon.symbol, want.symbol);
        check_field("header_mesh_kind", out_mon.header_mesh_kind, want.header_mesh_kind);
        check_field("fan_count", out_mon.fan_count, want.fan_count);
        check_field("out_x", out_mon.out_x, want.out_x);
        check_field("out_y", out_mon.out_y, want.out_y);
        check_field("out_z", out_mon.out_z, want.out_z);
        check_field("handle_from", out_mon.handle_from, want.handle_from);
        check_field("handle_to", out_mon.handle_to, want.handle_to);
        check_field("last", out_mon.last, want.last);
        check_field("done_res", out_mon.done_res, want.done_res);
        check_field("error", out_mon.error, want.error);
    endtask

    always @(posedge clk or negedge rst_n) begin
        in_item_t it;
        if (!rst_n) begin
            for (int i = 0; i < NUM_VERTS; i++)
                marked[i] = 0;
            for (int i = 0; i < NUM_TRIS; i++)
                tri_label[i] = '0;
            tri_count = '0;
            split_sp = 0;
            fan_count = '0;
            fan_stop = '0;
            cur_corner = '0;
            trav = TR_IDLE;
            mesh_kind = 1'b0;
            emit_header = 1'b1;
            fails = 0;
            n_checked = 0;
            n_done = 0;
            n_overflow = 0;
            expected_records.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_MESH_KIND)
                    mesh_kind = cfg_data;
                else
                    emit_header = cfg_data;
            end
            if (in_mon.valid && in_mon.ready) begin
                it.command         = in_mon.command;
                it.index           = in_mon.index;
                it.corner_vertex   = in_mon.corner_vertex;
                it.corner_opposite = in_mon.corner_opposite;
                it.coord_x         = in_mon.coord_x;
                it.coord_y         = in_mon.coord_y;
                it.coord_z         = in_mon.coord_z;
                predict_records(it);
            end
            if (out_mon.valid && out_mon.ready)
                compare_record();
        end
        mismatches      <= fails;
        pending         <= expected_records.size();
        records_checked <= n_checked;
        done_seen       <= n_done;
        overflow_seen   <= n_overflow;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import mcce_pkg::*;
    import mcce_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE = 200;

    bit   clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;

    int mismatches;
    int pending;
    int records_checked;
    int done_seen;
    int overflow_seen;
    int items_sent;
    int burst_left;
    int cycles;
    bit hold_req;

    mcce_in_if  in_ch();
    mcce_out_if out_ch();

    mesh_connectivity_clers_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mcce_clers_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .records_checked (records_checked),
        .done_seen       (done_seen),
        .overflow_seen   (overflow_seen)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d records outstanding.", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: runs of ready, stalls and random ready, plus a single long hold-off.
    initial begin
        int n;
        int mode;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else begin
                n = $urandom_range(1, 24);
                mode = $urandom_range(0, 3);
                repeat (n) begin
                    case (mode)
                        0, 1:    out_ch.ready <= 1'b1;
                        2:       out_ch.ready <= 1'b0;
                        default: out_ch.ready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(command_t cmd, logic [13:0] idx, logic [11:0] cv, logic [13:0] co,
                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid           <= 1'b1;
        in_ch.command         <= cmd;
        in_ch.index           <= idx;
        in_ch.corner_vertex   <= cv;
        in_ch.corner_opposite <= co;
        in_ch.coord_x         <= x;
        in_ch.coord_y         <= y;
        in_ch.coord_z         <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic load_corner(int idx, int vert, int opp);
        send(CMD_LOAD_CORNER, idx, vert, opp, $urandom, $urandom, $urandom);
    endtask

    task automatic load_vertex(int idx);
        send(CMD_LOAD_VERTEX, idx, $urandom, $urandom, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic start_at(int idx);
        send(CMD_START, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic step();
        send(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Stop offering, then wait for the last record and let any silent step finish.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Writes never read back: corners lie outside every traversal region, vertices are loaded again.
    task automatic noise_loads(int count);
        repeat (count) begin
            if ($urandom_range(0, 1))
                load_corner($urandom_range(4096, 16383), $urandom_range(0, 4095),
                            $urandom_range(0, 16383));
            else
                load_vertex($urandom_range(0, 16383));
        end
    endtask

    // Arbitrary connectivity confined to a small loaded region. Corner 1 always
    // carries an opposite past the table, which the block stores as corner 0.
    task automatic run_tangle(int ntri, int nvert, int start_idx, int nsteps);
        noise_loads($urandom_range(1, 4));
        for (int v = 0; v < nvert; v++)
            load_vertex(v);
        for (int c = 0; c < 3 * ntri; c++)
            load_corner(c, $urandom_range(0, nvert - 1),
                        (c == 1 || $urandom_range(0, 9) == 0) ?
                        $urandom_range(NUM_CORNERS, 16383) : $urandom_range(0, 3 * ntri - 1));
        start_at(start_idx);
        repeat (nsteps) step();
    endtask

    // Closed torus grid of m by n vertices, two triangles per cell.
    task automatic run_torus(int m, int n, bit long_hold);
        int tv[300];
        int op[300];
        int nc;
        int t;
        int a;
        int b;
        int c;
        int d;
        int p;
        int q;
        nc = 6 * m * n;
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < n; j++) begin
                a = i * n + j;
                b = ((i + 1) % m) * n + j;
                c = ((i + 1) % m) * n + (j + 1) % n;
                d = i * n + (j + 1) % n;
                t = 6 * (i * n + j);
                tv[t] = a;     tv[t + 1] = b; tv[t + 2] = c;
                tv[t + 3] = a; tv[t + 4] = c; tv[t + 5] = d;
            end
        end
        // The opposite corner sits across the same edge, walked the other way.
        for (int k = 0; k < nc; k++) begin
            p = tv[k - k % 3 + (k % 3 + 1) % 3];
            q = tv[k - k % 3 + (k % 3 + 2) % 3];
            op[k] = 0;
            for (int k2 = 0; k2 < nc; k2++)
                if (tv[k2 - k2 % 3 + (k2 % 3 + 1) % 3] == q &&
                    tv[k2 - k2 % 3 + (k2 % 3 + 2) % 3] == p)
                    op[k] = k2;
        end
        noise_loads($urandom_range(1, 4));
        for (int v = 0; v < m * n; v++)
            load_vertex(v);
        for (int k = 0; k < nc; k++)
            load_corner(k, tv[k], op[k]);
        start_at($urandom_range(0, nc - 1));
        if (long_hold)
            hold_req = 1'b1;
        repeat (nc / 3 + 12) step();
    endtask

    initial begin
        int directed_items;
        int phase_no;
        bit held;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data  <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.command         <= '0;
        in_ch.index           <= '0;
        in_ch.corner_vertex   <= '0;
        in_ch.corner_opposite <= '0;
        in_ch.coord_x         <= '0;
        in_ch.coord_y         <= '0;
        in_ch.coord_z         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: step while idle, out-of-range loads, a start index past the table.
        step();
        send(CMD_LOAD_CORNER, 14'h3FFF, 12'hFFF, 14'h3FFF, '1, '1, '1);
        send(CMD_LOAD_VERTEX, 14'h3FFF, '0, '0, '1, '1, '1);
        send(CMD_LOAD_VERTEX, NUM_VERTS, '0, '0, '0, '0, '0);
        run_tangle(2, 3, 16383, 8);
        settle();
        directed_items = items_sent;

        phase_no = 0;
        held = 1'b0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            write_cfg(CFG_MESH_KIND, phase_no[0]);
            write_cfg(CFG_EMIT_HEADER, phase_no[1]);
            if (phase_no % 3 == 2) begin
                run_tangle($urandom_range(2, 20), $urandom_range(3, 16), $urandom_range(0, 5),
                           $urandom_range(5, 30));
            end
            else begin
                run_torus($urandom_range(3, 5), $urandom_range(3, 5), !held);
                held = 1'b1;
            end
            settle();
            phase_no++;
        end

        $display("Sent %0d input transactions over %0d random phases after the directed cases.",
                 items_sent, phase_no);
        $display("Checked %0d records: %0d finished traversals, %0d overflow aborts.",
                 records_checked, done_seen, overflow_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
